// ===== sv/pep_pkg.sv =====
// shared types and constants of the postfix expression evaluator
`default_nettype none
package pep_pkg;

	localparam int VAL_W = 48;
	localparam int SYM_W = 8;
	localparam int STAT_W = 3;

	localparam logic [SYM_W-1:0] CH_ADD  = 8'h2B;
	localparam logic [SYM_W-1:0] CH_SUB  = 8'h2D;
	localparam logic [SYM_W-1:0] CH_MUL  = 8'h2A;
	localparam logic [SYM_W-1:0] CH_DIV  = 8'h2F;
	localparam logic [SYM_W-1:0] CH_ZERO = 8'h30;
	localparam logic [SYM_W-1:0] CH_NINE = 8'h39;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 3'd0,
		STAT_SYNTAX    = 3'd1,
		STAT_UNDERFLOW = 3'd2,
		STAT_FULL      = 3'd3,
		STAT_DIV_ZERO  = 3'd4,
		STAT_SATURATED = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_RD_B,
		S_CAP_A,
		S_EXEC,
		S_ITER,
		S_RESOLVE,
		S_WRITE,
		S_FINISH,
		S_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    latch_in;
		logic    push;
		logic    rd_m1;
		logic    rd_m2;
		logic    cap_b;
		logic    cap_a;
		logic    addsub;
		logic    iter_step;
		logic    resolve;
		logic    write_res;
		logic    err_set;
		status_t err_code;
		logic    emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic fatal;
		logic is_op;
		logic op_mul;
		logic op_div;
		logic early;
		logic last;
		logic sp_lt2;
		logic sp_full;
		logic b_zero;
		logic iter_last;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

// ===== sv/pep_if.sv =====
// word channels of the postfix expression evaluator
`default_nettype none
interface pep_sym_if;
	logic                       valid;
	logic                       ready;
	logic [pep_pkg::SYM_W-1:0] symbol;
	logic                       last;
	modport source(output valid, symbol, last, input ready);
	modport sink(input valid, symbol, last, output ready);
endinterface

interface pep_res_if;
	logic                        valid;
	logic                        ready;
	logic signed [pep_pkg::VAL_W-1:0] value;
	logic [pep_pkg::STAT_W-1:0]  status;
	modport source(output valid, value, status, input ready);
	modport sink(input valid, value, status, output ready);
endinterface
`default_nettype wire

// ===== sv/pep_ctrl.sv =====
// controller state machine of the postfix expression evaluator
`default_nettype none
module pep_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire pep_pkg::stat_t stat,
	output pep_pkg::cmd_t       cmd
);

	pep_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pep_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			pep_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = pep_pkg::S_DISPATCH;
				end
			end
			pep_pkg::S_DISPATCH: begin
				state_d = pep_pkg::S_FINISH;
				if (!stat.fatal) begin
					if (stat.is_op) begin
						if (stat.early) begin
							cmd.err_set  = 1'b1;
							cmd.err_code = pep_pkg::STAT_SYNTAX;
						end else if (stat.sp_lt2) begin
							cmd.err_set  = 1'b1;
							cmd.err_code = pep_pkg::STAT_UNDERFLOW;
						end else begin
							cmd.rd_m1 = 1'b1;
							state_d   = pep_pkg::S_RD_B;
						end
					end else if (stat.sp_full) begin
						cmd.err_set  = 1'b1;
						cmd.err_code = pep_pkg::STAT_FULL;
					end else begin
						cmd.push = 1'b1;
					end
				end
			end
			pep_pkg::S_RD_B: begin
				cmd.cap_b = 1'b1;
				cmd.rd_m2 = 1'b1;
				state_d   = pep_pkg::S_CAP_A;
			end
			pep_pkg::S_CAP_A: begin
				cmd.cap_a = 1'b1;
				state_d   = pep_pkg::S_EXEC;
			end
			pep_pkg::S_EXEC: begin
				if (stat.op_div && stat.b_zero) begin
					cmd.err_set  = 1'b1;
					cmd.err_code = pep_pkg::STAT_DIV_ZERO;
					state_d      = pep_pkg::S_FINISH;
				end else if (stat.op_div || stat.op_mul) begin
					state_d = pep_pkg::S_ITER;
				end else begin
					cmd.addsub = 1'b1;
					state_d    = pep_pkg::S_WRITE;
				end
			end
			pep_pkg::S_ITER: begin
				cmd.iter_step = 1'b1;
				if (stat.iter_last) begin
					state_d = pep_pkg::S_RESOLVE;
				end
			end
			pep_pkg::S_RESOLVE: begin
				cmd.resolve = 1'b1;
				state_d     = pep_pkg::S_WRITE;
			end
			pep_pkg::S_WRITE: begin
				cmd.write_res = 1'b1;
				state_d       = pep_pkg::S_FINISH;
			end
			pep_pkg::S_FINISH: begin
				if (!stat.last) begin
					state_d = pep_pkg::S_IDLE;
				end else begin
					cmd.rd_m1 = 1'b1;
					if (stat.early) begin
						cmd.err_set  = 1'b1;
						cmd.err_code = pep_pkg::STAT_SYNTAX;
					end
					state_d = pep_pkg::S_EMIT;
				end
			end
			pep_pkg::S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = pep_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pep_pkg::S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/pep_dp.sv =====
// datapath of the postfix expression evaluator: stack memory, alu, output register
`default_nettype none
module pep_dp #(
	parameter int STACK_DEPTH   = 64,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [pep_pkg::SYM_W-1:0] in_symbol,
	input  wire logic          in_last,
	input  wire pep_pkg::cmd_t cmd,
	output pep_pkg::stat_t     stat,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic signed [pep_pkg::VAL_W-1:0] out_value,
	output logic [pep_pkg::STAT_W-1:0]       out_status
);

	localparam int W     = pep_pkg::VAL_W;
	localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SPW   = $clog2(STACK_DEPTH + 1);
	localparam int DW    = W + FRACTION_BITS;
	localparam int CW    = $clog2(DW);
	localparam int ACC_W = 2 * W;
	localparam int CHK   = W / 3;

	localparam logic [W-1:0] VAL_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] VAL_MIN = {1'b1, {(W-1){1'b0}}};

	logic [W-1:0] mem [STACK_DEPTH];
	logic [W-1:0] rd_q;

	logic [SPW-1:0] sp_q;
	logic [1:0]     pos_q;
	pep_pkg::status_t err_q;
	logic [pep_pkg::SYM_W-1:0] sym_q;
	logic           last_q, early_q;
	pep_pkg::op_t   op_q;

	logic [W-1:0]     b_q;
	logic [W-1:0]     a_mag_q, b_mag_q;
	logic             neg_q;
	logic [CW-1:0]    cnt_q;
	logic [ACC_W-1:0] acc_q;
	logic [W-1:0]     rem_q;
	logic [DW-1:0]    dvd_q;
	logic [W-1:0]     quo_q;
	logic             big_q;
	logic [W-1:0]     r_q;
	logic             sat_q;

	logic             fatal;
	logic [SPW-1:0]   sp_m1, sp_m2;
	logic             is_digit, is_op;
	logic [pep_pkg::SYM_W-1:0] dig;
	logic [W-1:0]     lit;
	logic [W-1:0]     mag_b, mag_rd;
	logic [15:0]      chunk;
	logic [63:0]      pp;
	logic [ACC_W-1:0] pp_sh;
	logic [W:0]       rem_sh, div_diff;
	logic             div_ge;
	logic [ACC_W-1:0] prod;
	logic [W-1:0]     res_mag;
	logic             res_big;
	logic [W-1:0]     res_val;
	logic             res_sat;
	logic [W:0]       sum;

	assign fatal = (err_q == pep_pkg::STAT_SYNTAX) || (err_q == pep_pkg::STAT_UNDERFLOW) ||
		(err_q == pep_pkg::STAT_FULL) || (err_q == pep_pkg::STAT_DIV_ZERO);
	assign sp_m1 = sp_q - SPW'(1);
	assign sp_m2 = sp_q - SPW'(2);

	assign is_op = (sym_q == pep_pkg::CH_ADD) || (sym_q == pep_pkg::CH_SUB) ||
		(sym_q == pep_pkg::CH_MUL) || (sym_q == pep_pkg::CH_DIV);
	assign is_digit = (sym_q >= pep_pkg::CH_ZERO) && (sym_q <= pep_pkg::CH_NINE);
	assign dig = sym_q - pep_pkg::CH_ZERO;
	assign lit = is_digit ? (W'(dig[3:0]) << FRACTION_BITS) : '0;

	assign mag_b  = b_q[W-1] ? (~b_q + W'(1)) : b_q;
	assign mag_rd = rd_q[W-1] ? (~rd_q + W'(1)) : rd_q;

	// multiply: one 48x16 partial product per step
	always_comb begin
		case (cnt_q[1:0])
			2'd0:    chunk = b_mag_q[CHK-1:0];
			2'd1:    chunk = b_mag_q[2*CHK-1:CHK];
			default: chunk = b_mag_q[3*CHK-1:2*CHK];
		endcase
	end
	assign pp = {16'b0, a_mag_q} * {48'b0, chunk};
	always_comb begin
		case (cnt_q[1:0])
			2'd0:    pp_sh = ACC_W'(pp);
			2'd1:    pp_sh = ACC_W'(pp) << CHK;
			default: pp_sh = ACC_W'(pp) << (2 * CHK);
		endcase
	end

	// restoring divide, one quotient bit per step
	assign rem_sh   = {rem_q, dvd_q[DW-1]};
	assign div_diff = rem_sh - {1'b0, b_mag_q};
	assign div_ge   = rem_sh >= {1'b0, b_mag_q};

	assign prod = acc_q >> FRACTION_BITS;
	always_comb begin
		if (op_q == pep_pkg::OP_MUL) begin
			res_mag = prod[W-1:0];
			res_big = |prod[ACC_W-1:W];
		end else begin
			res_mag = quo_q;
			res_big = big_q;
		end
		if (res_big || (neg_q ? (res_mag > VAL_MIN) : (res_mag > VAL_MAX))) begin
			res_sat = 1'b1;
			res_val = neg_q ? VAL_MIN : VAL_MAX;
		end else begin
			res_sat = 1'b0;
			res_val = neg_q ? (~res_mag + W'(1)) : res_mag;
		end
	end

	assign sum = (op_q == pep_pkg::OP_SUB) ? ({rd_q[W-1], rd_q} - {b_q[W-1], b_q}) :
		({rd_q[W-1], rd_q} + {b_q[W-1], b_q});

	// a_q is not kept; first operand stays in rd_q until cap_a / addsub use it
	// stack memory
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[sp_q[AW-1:0]] <= lit;
		end else if (cmd.write_res) begin
			mem[sp_m2[AW-1:0]] <= r_q;
		end
		if (cmd.rd_m1) begin
			rd_q <= mem[sp_m1[AW-1:0]];
		end else if (cmd.rd_m2) begin
			rd_q <= mem[sp_m2[AW-1:0]];
		end
	end

	// payload and arithmetic registers
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			sym_q  <= in_symbol;
			last_q <= in_last;
			case (in_symbol)
				pep_pkg::CH_SUB: op_q <= pep_pkg::OP_SUB;
				pep_pkg::CH_MUL: op_q <= pep_pkg::OP_MUL;
				pep_pkg::CH_DIV: op_q <= pep_pkg::OP_DIV;
				default:         op_q <= pep_pkg::OP_ADD;
			endcase
		end
		if (cmd.cap_b) begin
			b_q <= rd_q;
		end
		if (cmd.cap_a) begin
			a_mag_q <= mag_rd;
			b_mag_q <= mag_b;
			neg_q   <= rd_q[W-1] ^ b_q[W-1];
			cnt_q   <= '0;
			acc_q   <= '0;
			rem_q   <= '0;
			dvd_q   <= DW'(mag_rd) << FRACTION_BITS;
			quo_q   <= '0;
			big_q   <= 1'b0;
		end
		if (cmd.iter_step) begin
			cnt_q <= cnt_q + CW'(1);
			if (op_q == pep_pkg::OP_MUL) begin
				acc_q <= acc_q + pp_sh;
			end else begin
				rem_q <= div_ge ? div_diff[W-1:0] : rem_sh[W-1:0];
				dvd_q <= dvd_q << 1;
				quo_q <= {quo_q[W-2:0], div_ge};
				big_q <= big_q | quo_q[W-1];
			end
		end
		if (cmd.addsub) begin
			if (sum[W] != sum[W-1]) begin
				r_q   <= sum[W] ? VAL_MIN : VAL_MAX;
				sat_q <= 1'b1;
			end else begin
				r_q   <= sum[W-1:0];
				sat_q <= 1'b0;
			end
		end else if (cmd.resolve) begin
			r_q   <= res_val;
			sat_q <= res_sat;
		end
	end

	// expression control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q    <= '0;
			pos_q   <= '0;
			err_q   <= pep_pkg::STAT_OK;
			early_q <= 1'b0;
		end else begin
			if (cmd.latch_in) begin
				early_q <= pos_q < 2'd2;
				if (pos_q < 2'd2) begin
					pos_q <= pos_q + 2'd1;
				end
			end
			if (cmd.push) begin
				sp_q <= sp_q + SPW'(1);
			end else if (cmd.write_res) begin
				sp_q <= sp_m1;
				if (sat_q && (err_q == pep_pkg::STAT_OK)) begin
					err_q <= pep_pkg::STAT_SATURATED;
				end
			end
			if (cmd.err_set && !fatal) begin
				err_q <= cmd.err_code;
			end
			if (cmd.emit) begin
				sp_q  <= '0;
				pos_q <= '0;
				err_q <= pep_pkg::STAT_OK;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_value  <= (!fatal && (sp_q != '0)) ? rd_q : '0;
			out_status <= err_q;
		end
	end

	always_comb begin
		stat.fatal     = fatal;
		stat.is_op     = is_op;
		stat.op_mul    = op_q == pep_pkg::OP_MUL;
		stat.op_div    = op_q == pep_pkg::OP_DIV;
		stat.early     = early_q;
		stat.last      = last_q;
		stat.sp_lt2    = sp_q < SPW'(2);
		stat.sp_full   = sp_q == SPW'(STACK_DEPTH);
		stat.b_zero    = b_q == '0;
		stat.iter_last = (op_q == pep_pkg::OP_MUL) ? (cnt_q == CW'(2)) : (cnt_q == CW'(DW - 1));
		stat.out_free  = !out_valid || out_ready;
	end

endmodule
`default_nettype wire

// ===== sv/postfix_expression_evaluator.sv =====
// top level of the postfix expression evaluator
// usage:
//   in_ch carries one expression character per word (symbol, last); last marks
//   the final character. out_ch carries one word per expression: value, the
//   signed fixed-point top of stack, and status (ok, syntax, underflow, stack
//   full, divide by zero, saturated).
// sequencing:
//   one character is handled at a time; ready is high only while the
//   controller waits for a word. a digit is pushed; an operator reads b,
//   then a, then + and - add or subtract, * sums three 48x16 partial
//   products and / runs a restoring divider, one quotient bit per cycle;
//   the result is written back in place of a. on the final character the
//   top of stack is read, then the result loads into the output register.
// reset and stall:
//   arst_n clears the stack pointer, position and error state; stack memory
//   contents are not cleared. a stalled receiver holds the result in the
//   output register; the next expression is accepted meanwhile and waits at
//   its own last character until the register frees.
`default_nettype none
module postfix_expression_evaluator #(
	parameter int STACK_DEPTH   = 64,
	parameter int FRACTION_BITS = 16
) (
	input wire logic  clk,
	input wire logic  arst_n,
	pep_sym_if.sink   in_ch,
	pep_res_if.source out_ch
);

	pep_pkg::cmd_t  cmd;
	pep_pkg::stat_t stat;

	// sequencing of one character at a time
	pep_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// stack, arithmetic and result register
	pep_dp #(
		.STACK_DEPTH   (STACK_DEPTH),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_symbol  (in_ch.symbol),
		.in_last    (in_ch.last),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_value  (out_ch.value),
		.out_status (out_ch.status)
	);

endmodule
`default_nettype wire
